/* hw/rtl/swhc_pkg.sv */
// Shared types and constants for the sliding window hit counter.
package swhc_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam logic [15:0] WINDOW_RESET = 16'd300;

  localparam int TS_W = 31;
  localparam int WIN_W = 16;
  localparam int CNT_OUT_W = 11;

  localparam logic ACT_HIT = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                 dropped;
    logic [CNT_OUT_W-1:0] hit_count;
  } res_t;

endpackage

/* hw/rtl/swhc_ring.sv */
// Timestamp ring memory: one write port, one registered read port.
module swhc_ring import swhc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  input  logic [TS_W-1:0]                wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  output logic [TS_W-1:0]                rd_data
);

  logic [TS_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/swhc_search.sv */
// Ring control: appends hits, binary-searches and retires entries on queries.
module swhc_search import swhc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [TS_W-1:0]                in_ts,
  input  logic [WIN_W-1:0]               window,
  output logic                           res_valid,
  input  logic                           res_ready,
  output res_t                           res,
  output logic                           wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  output logic [TS_W-1:0]                wr_data,
  output logic                           rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  input  logic [TS_W-1:0]                rd_data
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int PTR_W = ADDR_W + 1;
  localparam logic [PTR_W:0] TWO_D = (PTR_W+1)'(2 * STORE_DEPTH);
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(STORE_DEPTH);
  localparam logic [ADDR_W:0] DEPTH_A = (ADDR_W+1)'(STORE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_SRD  = 3'd2;
  localparam logic [2:0] ST_SCMP = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   cnt;
  logic [ADDR_W-1:0]  lo;
  logic [ADDR_W-1:0]  hi;
  logic [ADDR_W-1:0]  mid;
  logic signed [32:0] bnd;

  logic [PTR_W-1:0]   cnt_now;
  logic [PTR_W:0]     cnt_sum;
  logic               accept;
  logic               le;
  logic [ADDR_W-1:0]  lo_n;
  logic [ADDR_W-1:0]  hi_n;
  logic [ADDR_W-1:0]  mid_n;
  logic [PTR_W:0]     head_sum;
  logic [PTR_W-1:0]   head_adv;
  logic [PTR_W-1:0]   remain;

  // ring slot of position pos + off, both taken modulo the depth
  function automatic logic [ADDR_W-1:0] slot_of(logic [PTR_W-1:0] pos,
                                                logic [ADDR_W-1:0] off);
    logic [PTR_W-1:0] s;
    logic [ADDR_W:0]  t;
    s = (pos >= DEPTH_P) ? pos - DEPTH_P : pos;
    t = (ADDR_W+1)'(s) + (ADDR_W+1)'(off);
    if (t >= DEPTH_A) begin
      t = t - DEPTH_A;
    end
    return t[ADDR_W-1:0];
  endfunction

  assign cnt_sum = {1'b0, tail} + TWO_D - {1'b0, head};
  assign cnt_now = (tail >= head) ? tail - head : cnt_sum[PTR_W-1:0];
  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign res_valid = (state == ST_DONE);
  assign le = ($signed({2'b00, rd_data}) <= bnd);

  assign lo_n = le ? mid + 1'b1 : lo;
  assign hi_n = le ? hi : mid;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);
  assign head_sum = {1'b0, head} + (PTR_W+1)'(lo_n);
  assign head_adv = (head_sum >= TWO_D) ? PTR_W'(head_sum - TWO_D)
                                        : head_sum[PTR_W-1:0];
  assign remain = cnt - PTR_W'(lo_n);

  always_comb begin
    wr_en = accept && (in_action == ACT_HIT) && (cnt_now != DEPTH_P);
    wr_addr = slot_of(tail, '0);
    wr_data = in_ts;
    rd_en = 1'b0;
    rd_addr = slot_of(head, mid);
    unique case (state)
      ST_IDLE: begin
        rd_en = accept && (in_action == ACT_QUERY) && (cnt_now != '0);
        rd_addr = slot_of(head, ADDR_W'(cnt_now - 1'b1));
      end
      ST_SRD: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      tail <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res <= '{dropped: (in_action == ACT_HIT) && (cnt_now == DEPTH_P),
                     hit_count: '0};
            cnt <= cnt_now;
            bnd <= $signed({2'b00, in_ts}) - $signed({17'd0, window});
            if (in_action == ACT_HIT) begin
              state <= ST_DONE;
              if (cnt_now != DEPTH_P) begin
                tail <= (tail == PTR_W'(TWO_D - 1'b1)) ? '0 : tail + 1'b1;
              end
            end else if (cnt_now == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          lo <= '0;
          hi <= ADDR_W'(cnt - 1'b1);
          mid <= ADDR_W'((cnt - 1'b1) >> 1);
          if (le) begin
            // newest entry is old too: retire everything
            head <= tail;
            state <= ST_DONE;
          end else if (cnt == PTR_W'(1)) begin
            res.hit_count <= CNT_OUT_W'(32'(cnt));
            state <= ST_DONE;
          end else begin
            state <= ST_SRD;
          end
        end
        ST_SRD: begin
          state <= ST_SCMP;
        end
        ST_SCMP: begin
          lo <= lo_n;
          hi <= hi_n;
          mid <= mid_n;
          if (lo_n < hi_n) begin
            state <= ST_SRD;
          end else begin
            head <= head_adv;
            res.hit_count <= CNT_OUT_W'(32'(remain));
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_now <= DEPTH_P) else $error("live count exceeds store depth");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head} < TWO_D) && ({1'b0, tail} < TWO_D))
    else $error("ring position out of range");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.dropped |-> res.hit_count == '0)
    else $error("dropped hit carries a count");

  a_hit_adv: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> tail != $past(tail)) else $error("stored hit did not advance tail");

  a_no_rw: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en)) else $error("ring read and write in one cycle");
`endif

endmodule

/* hw/rtl/sliding_window_hit_counter_top.sv */
// Sliding window hit counter: stream ports, window register, output stage.
//
// Input stream s_axis: tuser[0] is the action (0 records a hit, 1 queries),
// tdata[30:0] the timestamp, non-decreasing from item to item. Each input
// item yields exactly one result item on m_axis: tdata[10:0] is the count of
// hits newer than timestamp - window for a query (zero for a hit), and
// tuser[0] flags a hit dropped because the ring of STORE_DEPTH entries was
// full. cfg_wr_en/cfg_wr_data set the window; write it only while idle.
// Items are processed one at a time. An accepted hit goes straight to the
// done state, then through the output register to m_axis. A query reads the
// newest live entry, then binary-searches the ring with one memory read and
// one compare per step. A finished result waits in the output register while
// the next item is taken; a stalled m_axis holds the block once that result
// and the next one are both complete. Reset empties the ring at once (no
// clearing pass), sets the window to 300 and clears m_axis_tvalid.
module sliding_window_hit_counter_top import swhc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] timestamp
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] hit_count
  output logic [0:0]  m_axis_tuser,   // [0] dropped
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic [WIN_W-1:0]  window;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [TS_W-1:0]   wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [TS_W-1:0]   rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window <= cfg_wr_data;
    end
  end

  swhc_search #(.STORE_DEPTH(STORE_DEPTH)) u_search (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser[0]),
    .in_ts     (s_axis_tdata[TS_W-1:0]),
    .window    (window),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  swhc_ring #(.STORE_DEPTH(STORE_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // load the output register when it is empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {5'd0, res.hit_count};
      m_axis_tuser <= res.dropped;
    end
  end

endmodule

/* tb/sv/swhc_monitor.sv */
// Stream monitor for the hit counter: predicts each result and compares it with the block's output.
module swhc_monitor import swhc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] timestamp
  input  logic [0:0]  s_axis_tuser,   // [0] action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [10:0] hit_count
  input  logic [0:0]  m_axis_tuser,   // [0] dropped
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_MOD = 2 * STORE_DEPTH;

  logic [TS_W-1:0]  stamps [STORE_DEPTH];
  int unsigned      head_pos;
  int unsigned      tail_pos;
  logic [WIN_W-1:0] window_len;
  res_t             expected_counts[$];
  int               errs;

  function automatic logic [TS_W-1:0] stamp_at(int unsigned offset);
    return stamps[((head_pos + offset) % POS_MOD) % STORE_DEPTH];
  endfunction

  // Apply one item to the shadow ring and return the result it should produce.
  function automatic res_t retire_and_count(logic act, logic [TS_W-1:0] ts);
    res_t        r;
    longint      cutoff;
    int unsigned live;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [31:0] remain;
    r = '0;
    live = (tail_pos + POS_MOD - head_pos) % POS_MOD;
    if (act == ACT_HIT) begin
      if (live >= STORE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        stamps[tail_pos % STORE_DEPTH] = ts;
        tail_pos = (tail_pos + 1) % POS_MOD;
      end
    end else begin
      cutoff = longint'(ts) - longint'(window_len);
      if (live == 0 || longint'(stamp_at(live - 1)) <= cutoff) begin
        head_pos = tail_pos;
      end else begin
        lo = 0;
        hi = live - 1;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (longint'(stamp_at(mid)) <= cutoff) lo = mid + 1;
          else hi = mid;
        end
        head_pos = (head_pos + lo) % POS_MOD;
        remain = live - lo;
        r.hit_count = remain[CNT_OUT_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      head_pos = 0;
      tail_pos = 0;
      window_len = WINDOW_RESET;
      expected_counts.delete();
    end else begin
      if (cfg_wr_en) window_len = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit_count = m_axis_tdata[CNT_OUT_W-1:0];
        got.dropped = m_axis_tuser[0];
        if (expected_counts.size() == 0) begin
          $error("result item with no item pending: hit_count %0d dropped %0d",
                 got.hit_count, got.dropped);
          errs++;
        end else begin
          want = expected_counts.pop_front();
          if (got.hit_count !== want.hit_count) begin
            $error("hit_count mismatch: expected %0d, actual %0d", want.hit_count, got.hit_count);
            errs++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped mismatch: expected %0d, actual %0d", want.dropped, got.dropped);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_counts = {expected_counts,
                           retire_and_count(s_axis_tuser[0], s_axis_tdata[TS_W-1:0])};
    end
    mismatches <= errs;
    outstanding <= expected_counts.size();
  end

endmodule

/* tb/sv/tb_sliding_window_hit_counter_top.sv */
// Testbench top for the sliding window hit counter: stimulus, handshake pacing and verdict.
module tb_sliding_window_hit_counter_top;
  import swhc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TS_MAX = 64'h7FFF_FFFF;
  // Quiet cycles allowed with no handshake on either stream: far above what a
  // query search plus an 81 percent stall rate will almost ever produce.
  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [30:0] timestamp
  logic [0:0]  s_axis_tuser = '0;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [10:0] hit_count
  logic [0:0]  m_axis_tuser;        // [0] dropped
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int     mismatches;
  int     outstanding;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     quiet_cycles = 0;
  longint ts_now = 1;

  always #10 clk = ~clk;

  sliding_window_hit_counter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  swhc_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Stall the result side at random.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic act, input logic [TS_W-1:0] ts);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, ts};
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold off until every result has come back, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly non-decreasing timestamps with steps scaled to the window, plus rare jumps.
  task automatic random_run(input logic [WIN_W-1:0] w, input int count);
    int  step_max;
    logic act;
    set_window(w);
    step_max = w / 64 + 1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        ts_now = $urandom_range(1, 32'h7FFF_FFFF);
      end else begin
        ts_now = ts_now + $urandom_range(0, step_max);
        if (ts_now > TS_MAX) ts_now = TS_MAX;
      end
      act = ($urandom_range(0, 99) < 25) ? ACT_QUERY : ACT_HIT;
      push_item(act, ts_now[TS_W-1:0]);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window at its reset value: empty ring, negative cutoff, partial and full retire.
    push_item(ACT_QUERY, 31'd1);
    push_item(ACT_HIT, 31'd1);
    push_item(ACT_HIT, 31'd1);
    push_item(ACT_HIT, 31'd2);
    push_item(ACT_QUERY, 31'd2);
    push_item(ACT_HIT, 31'd400);
    push_item(ACT_QUERY, 31'd401);
    push_item(ACT_QUERY, 31'd700);
    push_item(ACT_HIT, 31'h7FFF_FFFE);
    push_item(ACT_HIT, 31'h7FFF_FFFF);
    push_item(ACT_QUERY, 31'h7FFF_FFFF);
    // Out-of-order stamps leave the ring unsorted; the search result stands as is.
    push_item(ACT_HIT, 31'd5);
    push_item(ACT_QUERY, 31'h7FFF_FFFF);
    push_item(ACT_HIT, 31'd10);
    push_item(ACT_HIT, 31'd3);
    push_item(ACT_HIT, 31'd20);
    push_item(ACT_QUERY, 31'd305);

    set_window(16'd1);
    push_item(ACT_HIT, 31'd100);
    push_item(ACT_HIT, 31'd101);
    push_item(ACT_QUERY, 31'd101);
    push_item(ACT_QUERY, 31'd102);

    set_window(16'hFFFF);
    push_item(ACT_HIT, 31'h2AAA_AAAA);
    push_item(ACT_HIT, 31'h5555_5555);
    push_item(ACT_QUERY, 31'h5555_5555);

    // Fill the ring past its depth so the last hits drop, then retire half of it.
    push_item(ACT_QUERY, 31'h7FFF_FFFF);
    for (int i = 0; i < 1030; i++) push_item(ACT_HIT, 31'(1000 + i / 8));
    push_item(ACT_QUERY, 31'd1200);
    push_item(ACT_QUERY, 31'(1064 + 65535));
    for (int i = 0; i < 40; i++) push_item(ACT_HIT, 31'(66600 + i));
    push_item(ACT_QUERY, 31'(66640));
    ts_now = 66640;

    tx_idle_pct = 21;
    rx_idle_pct = 81;
    random_run(16'd1, 100);
    tx_idle_pct = 81;
    rx_idle_pct = 21;
    random_run(16'hFFFF, 100);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(16'($urandom_range(2, 65534)), 100);

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
